@@ sv/bf3_pkg.sv @@
`timescale 1ns / 1ps
package bf3_pkg;

  localparam int SIDE_PORT_W = 11;
  localparam int OUT_W = 16;
  localparam int FIFO_DEPTH = 8;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    DIV_ONE,
    DIV_FOUR,
    DIV_SIX,
    DIV_NINE
  } div_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic             frame_end;
  } out_word_t;

endpackage

@@ sv/bf3_ram.sv @@
`timescale 1ns / 1ps
module bf3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ sv/box_filter_3x3_rgb.sv @@
// 3x3 mean filter, RGB, square image, raster order.
// Throughput: one word per cycle (pixel or flush) while in_stall is low; the line stores take
// one read and one write per pixel, and the window and divider are fully pipelined.
// A result passes the b, c and d registers once the word that releases it is accepted (the word
// one row plus one pixel later, or a flush), then goes into the 8-deep output queue, where it may wait.
// Reset (rst, synchronous): side min(64, MAX_SIDE), positions zero, queue empty, line stores kept.
`timescale 1ns / 1ps
module box_filter_3x3_rgb #(
  parameter int MAX_SIDE = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bf3_pkg::SIDE_PORT_W-1:0]  image_side,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             opcode,
  input  logic [15:0]                      in_red,
  input  logic [15:0]                      in_green,
  input  logic [15:0]                      in_blue,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bf3_pkg::OUT_W-1:0]        out_red,
  output logic [bf3_pkg::OUT_W-1:0]        out_green,
  output logic [bf3_pkg::OUT_W-1:0]        out_blue,
  output logic                             frame_end
);

  localparam int CB = CHANNEL_BITS;
  localparam int PIX_W = 3 * CB;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int COL_W = $clog2(MAX_SIDE);
  localparam int ROW_W = $clog2(MAX_SIDE + 2);
  localparam int TOT_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int CNT_W = $clog2(bf3_pkg::FIFO_DEPTH + 1);
  localparam int PTR_W = $clog2(bf3_pkg::FIFO_DEPTH);
  localparam int SUM_W = CB + 4;
  localparam int K = SUM_W + 4;
  localparam int M_W = K - 1;
  localparam int M9 = ((1 << K) + 8) / 9;
  localparam int M6 = ((1 << K) + 5) / 6;
  localparam int RESET_SIDE = (MAX_SIDE < 64) ? MAX_SIDE : 64;
  localparam int RESET_TOTAL = RESET_SIDE * RESET_SIDE;

  // configuration and positions
  logic [SIDE_W-1:0] side;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  in_cnt;
  logic [TOT_W-1:0]  out_cnt;
  logic [ROW_W-1:0]  sh_row;
  logic [COL_W-1:0]  sh_col;
  logic [ROW_W-1:0]  q_row;
  logic [COL_W-1:0]  q_col;

  logic [SIDE_W-1:0]   cfg_side;
  logic [2*SIDE_W-1:0] cfg_sq;
  logic [SIDE_W-1:0]   side_m1;

  logic in_acc;
  logic is_pix;
  logic restart;
  logic emit;
  logic shift;
  logic [TOT_W-1:0] eff_in;
  logic [TOT_W-1:0] eff_out;
  logic [TOT_W-1:0] in_inc;
  logic [ROW_W-1:0] a_row;
  logic [COL_W-1:0] a_col;
  logic [ROW_W-1:0] q_r;
  logic [COL_W-1:0] q_c;
  logic a_wrap;
  logic q_wrap;
  logic top_ok;
  logic bot_ok;
  logic left_ok;
  logic right_ok;
  logic [8:0] a_mask;
  bf3_pkg::div_t a_div;
  logic [PIX_W-1:0] a_pix;

  // pipeline
  logic             b_shift;
  logic             b_emit;
  logic             b_par;
  logic [PIX_W-1:0] b_pix;
  logic [8:0]       b_mask;
  bf3_pkg::div_t    b_div;
  logic             b_end;
  logic [PIX_W-1:0] rd0;
  logic [PIX_W-1:0] rd1;
  logic [PIX_W-1:0] win [3][3];

  logic          c_emit;
  logic [8:0]    c_mask;
  bf3_pkg::div_t c_div;
  logic          c_end;
  logic [SUM_W-1:0] c_sum [3];

  logic          d_emit;
  bf3_pkg::div_t d_div;
  logic          d_end;
  logic [SUM_W-1:0] d_sum [3];
  logic [CB-1:0] d_quo [3];

  // output queue
  bf3_pkg::out_word_t fifo_mem [bf3_pkg::FIFO_DEPTH];
  bf3_pkg::out_word_t head;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fcount;
  logic [CNT_W-1:0] cred;
  logic             pop;

  function automatic logic [CB-1:0] divide(logic [SUM_W-1:0] s, bf3_pkg::div_t d);
    logic [SUM_W+M_W-1:0] m;
    logic [SUM_W+M_W-1:0] p;
    m = (d == bf3_pkg::DIV_NINE) ? (SUM_W + M_W)'(M9) : (SUM_W + M_W)'(M6);
    p = (SUM_W + M_W)'(s) * m;
    case (d)
      bf3_pkg::DIV_ONE:  divide = CB'(s);
      bf3_pkg::DIV_FOUR: divide = CB'(s >> 2);
      default:           divide = CB'(p >> K);
    endcase
  endfunction

  assign cfg_ready = 1'b1;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (cred == CNT_W'(bf3_pkg::FIFO_DEPTH));
  assign side_m1 = side - SIDE_W'(1);

  always_comb begin
    if (image_side == '0) begin
      cfg_side = SIDE_W'(1);
    end else if (32'(image_side) > MAX_SIDE) begin
      cfg_side = SIDE_W'(MAX_SIDE);
    end else begin
      cfg_side = SIDE_W'(image_side);
    end
    cfg_sq = (2 * SIDE_W)'(cfg_side) * (2 * SIDE_W)'(cfg_side);
  end

  always_comb begin
    is_pix  = (opcode == bf3_pkg::OP_PIXEL);
    restart = is_pix && (in_cnt >= total);
    eff_in  = restart ? '0 : in_cnt;
    eff_out = restart ? '0 : out_cnt;
    a_row   = restart ? '0 : sh_row;
    a_col   = restart ? '0 : sh_col;
    q_r     = restart ? '0 : q_row;
    q_c     = restart ? '0 : q_col;
    in_inc  = eff_in + TOT_W'(1);
    if (is_pix) begin
      emit = (in_inc >= TOT_W'(side) + TOT_W'(2)) && (eff_out < total);
    end else begin
      emit = (in_cnt == total) && (out_cnt < total);
    end
    shift  = is_pix || emit;
    a_wrap = (SIDE_W'(a_col) == side_m1);
    q_wrap = (SIDE_W'(q_c) == side_m1);

    top_ok   = (q_r != '0);
    bot_ok   = (q_r != ROW_W'(side_m1));
    left_ok  = (q_c != '0);
    right_ok = !q_wrap;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        a_mask[c*3+r] = ((r == 0) ? top_ok : (r == 2) ? bot_ok : 1'b1) &&
                        ((c == 0) ? left_ok : (c == 2) ? right_ok : 1'b1);
      end
    end
    if (side == SIDE_W'(1)) begin
      // one-pixel image: the pixel sits in the bottom slot of the middle column
      a_mask = 9'b000100000;
      a_div  = bf3_pkg::DIV_ONE;
    end else if (top_ok && bot_ok && left_ok && right_ok) begin
      a_div = bf3_pkg::DIV_NINE;
    end else if ((top_ok && bot_ok) || (left_ok && right_ok)) begin
      a_div = bf3_pkg::DIV_SIX;
    end else begin
      a_div = bf3_pkg::DIV_FOUR;
    end
    a_pix = {in_red[CB-1:0], in_green[CB-1:0], in_blue[CB-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side    <= SIDE_W'(RESET_SIDE);
      total   <= TOT_W'(RESET_TOTAL);
      in_cnt  <= '0;
      out_cnt <= '0;
      sh_row  <= '0;
      sh_col  <= '0;
      q_row   <= '0;
      q_col   <= '0;
    end else if (cfg_valid) begin
      side    <= cfg_side;
      total   <= TOT_W'(cfg_sq);
      in_cnt  <= '0;
      out_cnt <= '0;
      sh_row  <= '0;
      sh_col  <= '0;
      q_row   <= '0;
      q_col   <= '0;
    end else if (in_acc) begin
      if (is_pix) begin
        in_cnt <= in_inc;
      end
      if (shift) begin
        if (a_wrap) begin
          sh_row <= a_row + ROW_W'(1);
          sh_col <= '0;
        end else begin
          sh_row <= a_row;
          sh_col <= a_col + COL_W'(1);
        end
      end
      if (emit) begin
        out_cnt <= eff_out + TOT_W'(1);
        if (q_wrap) begin
          q_row <= q_r + ROW_W'(1);
          q_col <= '0;
        end else begin
          q_row <= q_r;
          q_col <= q_c + COL_W'(1);
        end
      end else if (restart) begin
        out_cnt <= '0;
        q_row   <= '0;
        q_col   <= '0;
      end
    end
  end

  // line stores: store k holds rows with parity k
  bf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_store0 (
    .clk   (clk),
    .we    (in_acc && is_pix && !a_row[0]),
    .waddr (a_col),
    .wdata (a_pix),
    .re    (in_acc && shift),
    .raddr (a_col),
    .rdata (rd0)
  );

  bf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_store1 (
    .clk   (clk),
    .we    (in_acc && is_pix && a_row[0]),
    .waddr (a_col),
    .wdata (a_pix),
    .re    (in_acc && shift),
    .raddr (a_col),
    .rdata (rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_shift <= 1'b0;
      b_emit  <= 1'b0;
      c_emit  <= 1'b0;
      d_emit  <= 1'b0;
    end else begin
      b_shift <= in_acc && shift;
      b_emit  <= in_acc && emit;
      c_emit  <= b_emit;
      d_emit  <= c_emit;
    end
    b_par  <= a_row[0];
    b_pix  <= a_pix;
    b_mask <= a_mask;
    b_div  <= a_div;
    b_end  <= !bot_ok && q_wrap;
    if (b_shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2][0] <= b_par ? rd1 : rd0;
      win[2][1] <= b_par ? rd0 : rd1;
      win[2][2] <= b_pix;
    end
    c_mask <= b_mask;
    c_div  <= b_div;
    c_end  <= b_end;
    d_sum  <= c_sum;
    d_div  <= c_div;
    d_end  <= c_end;
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      c_sum[ch] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (c_mask[c*3+r]) begin
            c_sum[ch] = c_sum[ch] + SUM_W'(win[c][r][ch*CB +: CB]);
          end
        end
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      d_quo[ch] = divide(d_sum[ch], d_div);
    end
  end

  assign head      = fifo_mem[rd_ptr];
  assign out_valid = (fcount != '0);
  assign pop       = out_valid && !out_stall;
  assign out_red   = head.red;
  assign out_green = head.green;
  assign out_blue  = head.blue;
  assign frame_end = head.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fcount <= '0;
      cred   <= '0;
    end else begin
      if (d_emit) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fcount <= fcount + CNT_W'(d_emit) - CNT_W'(pop);
      cred   <= cred + CNT_W'(in_acc && emit) - CNT_W'(pop);
    end
    if (d_emit) begin
      fifo_mem[wr_ptr] <= '{red:       bf3_pkg::OUT_W'(d_quo[2]),
                            green:     bf3_pkg::OUT_W'(d_quo[1]),
                            blue:      bf3_pkg::OUT_W'(d_quo[0]),
                            frame_end: d_end};
    end
  end

`ifndef SYNTH
  a_cred_bound: assert property (@(posedge clk) disable iff (rst)
    cred <= CNT_W'(bf3_pkg::FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_fifo_in_cred: assert property (@(posedge clk) disable iff (rst)
    fcount <= cred)
    else $error("queue holds more words than credits");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    d_emit |-> (fcount != CNT_W'(bf3_pkg::FIFO_DEPTH)) || pop)
    else $error("push into full output queue");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (out_cnt <= total) && (in_cnt <= total))
    else $error("frame position past image size");

  a_emit_shifts: assert property (@(posedge clk) disable iff (rst)
    b_emit |-> b_shift)
    else $error("result issued without window shift");
`endif

endmodule
